### rtl/core/assert_macros.svh
// Assertion macros used by the edge detector top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, off while reset is asserted.
`define SEM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Same-cycle implication.
`define SEM_ASSERT_IMPL(name, pre, post, msg) \
  `SEM_ASSERT(name, (pre) |-> (post), msg)

`endif

### rtl/core/sem_pkg.sv
// Shared types and constants of the Sobel edge magnitude stream unit.
package sem_pkg;

  localparam int PIX_W            = 8;
  localparam int FRAME_WIDTH_W    = 11;
  localparam int FRAME_HEIGHT_W   = 13;
  localparam int ROW_W            = 12;
  localparam int CFG_INDEX_W      = 1;
  localparam int CFG_DATA_W       = 13;
  localparam int MIN_DIM          = 3;
  localparam int MAX_FRAME_HEIGHT = 4096;
  localparam int FRAME_WIDTH_RST  = 640;
  localparam int FRAME_HEIGHT_RST = 480;

  // Gradient of one 3x3 window fits in -1020..1020
  localparam int GRAD_W = 11;

  // Result queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // Item kinds
  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_FLUSH = 1'b1;

  // Register map
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_e;

  // Classified request from the front part
  typedef struct packed {
    logic             valid;
    logic             pixel;
    logic             emit;
    logic             use_sobel;
    logic             last;
    logic [PIX_W-1:0] pix;
  } cmd_t;

  // Queue entry: gradients plus result flags
  typedef struct packed {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    logic                     use_sobel;
    logic                     last;
  } grad_t;

endpackage

### rtl/core/sobel_edge_magnitude_stream_unit.sv
// Top level of the streaming 3x3 Sobel edge detector with L1 magnitude.
//
// Pixels enter in raster order; each accepted item can release one result
// (|Gx|+|Gy| saturated to 255, zero on the frame border), which lags its
// pixel by frame_width+1 positions. Flush items push out the border zeros
// still pending after the last pixel; the final result of a frame has
// frame_last set. Sustained rate is one item per clock unless full: the line
// buffer RAM (MAX_LINE_WIDTH words of 16 bits) takes one read and one write
// per cycle, and a result passes the request register, queue and result
// register. full rises once the four-entry result queue plus the request in
// flight reach four, i.e. when five results wait untaken counting the one on
// the output ports. Line buffer contents are not cleared at reset; there is
// no clearing pass. Registers must be written only while the block is idle;
// the block does not enforce this. A write takes effect on the next item.
`include "assert_macros.svh"

module sobel_edge_magnitude_stream_unit import sem_pkg::*; #(
  parameter int MAX_LINE_WIDTH = 1024
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_valid_i,
  output logic                   cfg_ready_o,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                   push,
  output logic                   full,
  input  logic                   kind_i,
  input  logic [PIX_W-1:0]       pixel_in_i,
  output logic                   empty,
  input  logic                   pop,
  output logic [PIX_W-1:0]       edge_value_o,
  output logic                   frame_last_o
);

  localparam int CW = $clog2(MAX_LINE_WIDTH);

  logic              accept;
  logic [CW-1:0]     rd_addr, cmd_addr;
  cmd_t              cmd;
  logic              at_frame_start;
  logic              q_push, q_pop, q_valid, out_valid;
  grad_t             q_in, q_head;
  logic [QCNT_W-1:0] q_count;
  logic              req_last, req_restart, req_sobel;

  assign cfg_ready_o = 1'b1;
  assign accept      = push && !full;

  // Credit check: queued results plus the request in flight
  assign full = ((QCNT_W+1)'(q_count) + (QCNT_W+1)'(cmd.valid && cmd.emit))
                >= (QCNT_W+1)'(QUEUE_DEPTH);

  sem_front #(
    .MAX_LINE_WIDTH(MAX_LINE_WIDTH)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .accept_i        (accept),
    .kind_i          (kind_i),
    .pixel_i         (pixel_in_i),
    .rd_addr_o       (rd_addr),
    .cmd_addr_o      (cmd_addr),
    .cmd_o           (cmd),
    .at_frame_start_o(at_frame_start)
  );

  sem_grad #(
    .MAX_LINE_WIDTH(MAX_LINE_WIDTH)
  ) u_grad (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .cmd_addr_i(cmd_addr),
    .rd_addr_i (rd_addr),
    .push_o    (q_push),
    .grad_o    (q_in)
  );

  sem_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_in),
    .pop_i  (q_pop),
    .data_o (q_head),
    .valid_o(q_valid),
    .count_o(q_count)
  );

  sem_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (q_head),
    .head_valid_i(q_valid),
    .deq_o       (q_pop),
    .pop_i       (pop && !empty),
    .out_valid_o (out_valid),
    .edge_value_o(edge_value_o),
    .frame_last_o(frame_last_o)
  );

  assign empty = !out_valid;

  // Checks
  assign req_last    = cmd.valid && cmd.last;
  assign req_restart = cmd.emit && at_frame_start;
  assign req_sobel   = cmd.valid && cmd.use_sobel;

  `SEM_ASSERT_IMPL(a_queue_no_overflow, q_push, q_count < QCNT_W'(QUEUE_DEPTH), "queue overflow")
  `SEM_ASSERT_IMPL(a_last_restarts_frame, req_last, req_restart, "frame end without restart")
  `SEM_ASSERT_IMPL(a_sobel_only_on_pixel, req_sobel, cmd.pixel, "gradient without a pixel")

endmodule

### rtl/core/sem_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sem_ram #(
  parameter int Width = 8,
  parameter int Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/sem_front.sv
// Front part: configuration registers, raster position and item classification.
module sem_front import sem_pkg::*; #(
  parameter int MAX_LINE_WIDTH = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  input  logic [CFG_INDEX_W-1:0]            cfg_index_i,
  input  logic [CFG_DATA_W-1:0]             cfg_data_i,
  input  logic                              accept_i,
  input  logic                              kind_i,
  input  logic [PIX_W-1:0]                  pixel_i,
  output logic [$clog2(MAX_LINE_WIDTH)-1:0] rd_addr_o,
  output logic [$clog2(MAX_LINE_WIDTH)-1:0] cmd_addr_o,
  output cmd_t                              cmd_o,
  output logic                              at_frame_start_o
);

  localparam int CW  = $clog2(MAX_LINE_WIDTH);
  localparam int WEW = $clog2(MAX_LINE_WIDTH + 1);
  localparam int TW  = $clog2(MAX_LINE_WIDTH * MAX_FRAME_HEIGHT + 1);
  localparam int WRstEff = (FRAME_WIDTH_RST > MAX_LINE_WIDTH) ? MAX_LINE_WIDTH
                                                              : FRAME_WIDTH_RST;
  localparam int TotalRst = WRstEff * FRAME_HEIGHT_RST;

  logic [WEW-1:0]            weff_q, weff_d, w_clamped;
  logic [FRAME_HEIGHT_W-1:0] heff_q, heff_d, h_clamped;
  logic [TW-1:0]             total_q, total_d;
  logic [FRAME_WIDTH_W-1:0]  cfg_fw;
  logic [FRAME_HEIGHT_W-1:0] cfg_fh;

  logic [CW-1:0]    col_q, col_d, col_nx;
  logic [ROW_W-1:0] row_q, row_d, row_nx;
  logic [TW-1:0]    oe_q, oe_d, oe_inc;
  logic [CW:0]      col_inc;
  logic [ROW_W:0]   row_inc;
  logic             col_wrap, row_wrap, draining, done, emit_pix, use_sobel;
  cmd_t             cmd_q, cmd_d;
  logic [CW-1:0]    cmd_addr_q;

  // Clamp written sizes to the supported range
  assign cfg_fw = cfg_data_i[FRAME_WIDTH_W-1:0];
  assign cfg_fh = cfg_data_i[FRAME_HEIGHT_W-1:0];

  always_comb begin
    if (int'(cfg_fw) < MIN_DIM) begin
      w_clamped = WEW'(MIN_DIM);
    end else if (int'(cfg_fw) > MAX_LINE_WIDTH) begin
      w_clamped = WEW'(MAX_LINE_WIDTH);
    end else begin
      w_clamped = WEW'(cfg_fw);
    end
    if (int'(cfg_fh) < MIN_DIM) begin
      h_clamped = FRAME_HEIGHT_W'(MIN_DIM);
    end else if (int'(cfg_fh) > MAX_FRAME_HEIGHT) begin
      h_clamped = FRAME_HEIGHT_W'(MAX_FRAME_HEIGHT);
    end else begin
      h_clamped = cfg_fh;
    end
  end

  // Register writes; frame size product kept alongside
  always_comb begin
    weff_d = weff_q;
    heff_d = heff_q;
    if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_FRAME_WIDTH:  weff_d = w_clamped;
        REG_FRAME_HEIGHT: heff_d = h_clamped;
        default: ;
      endcase
    end
    total_d = TW'(weff_d) * TW'(heff_d);
  end

  // Raster position of the next pixel
  assign col_inc  = {1'b0, col_q} + 1'b1;
  assign row_inc  = {1'b0, row_q} + 1'b1;
  assign col_wrap = col_inc >= (CW+1)'(weff_q);
  assign row_wrap = row_inc >= (ROW_W+1)'(heff_q);
  assign col_nx   = col_wrap ? '0 : col_inc[CW-1:0];
  assign row_nx   = col_wrap ? (row_wrap ? '0 : row_inc[ROW_W-1:0]) : row_q;

  // A pixel past the first row and one column releases a result
  assign emit_pix  = col_wrap ? (row_wrap || (row_q != '0))
                              : ((row_q >= ROW_W'(2)) || ((row_q == ROW_W'(1)) && (col_q != '0)));
  assign use_sobel = (row_q >= ROW_W'(2)) && (col_q >= CW'(2));

  // Output count of the frame
  assign oe_inc   = oe_q + 1'b1;
  assign done     = oe_inc >= total_q;
  assign draining = (col_q == '0) && (row_q == '0) && (oe_q != '0);

  // Classify the accepted item
  always_comb begin
    col_d      = col_q;
    row_d      = row_q;
    oe_d       = oe_q;
    cmd_d      = '0;
    cmd_d.pix  = pixel_i;
    if (accept_i) begin
      if (draining) begin
        cmd_d.valid = 1'b1;
        cmd_d.emit  = 1'b1;
        cmd_d.last  = done;
        oe_d        = done ? '0 : oe_inc;
      end else if (kind_i == KIND_PIXEL) begin
        cmd_d.valid     = 1'b1;
        cmd_d.pixel     = 1'b1;
        cmd_d.use_sobel = use_sobel;
        cmd_d.emit      = emit_pix;
        col_d           = col_nx;
        row_d           = row_nx;
        if (emit_pix) begin
          cmd_d.last = done;
          oe_d       = done ? '0 : oe_inc;
        end
      end
      // Frame complete: back to the first position
      if (cmd_d.emit && done) begin
        col_d = '0;
        row_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      weff_q  <= WEW'(WRstEff);
      heff_q  <= FRAME_HEIGHT_W'(FRAME_HEIGHT_RST);
      total_q <= TW'(TotalRst);
      col_q   <= '0;
      row_q   <= '0;
      oe_q    <= '0;
      cmd_q   <= '0;
    end else begin
      weff_q  <= weff_d;
      heff_q  <= heff_d;
      total_q <= total_d;
      col_q   <= col_d;
      row_q   <= row_d;
      oe_q    <= oe_d;
      cmd_q   <= cmd_d;
    end
  end

  // Line buffer column of the request in flight
  always_ff @(posedge clk_i) begin
    cmd_addr_q <= col_q;
  end

  assign rd_addr_o        = col_q;
  assign cmd_addr_o       = cmd_addr_q;
  assign cmd_o            = cmd_q;
  assign at_frame_start_o = (col_q == '0) && (row_q == '0) && (oe_q == '0);

endmodule

### rtl/core/sem_grad.sv
// Line buffer, 3x3 window and Sobel gradients of each classified request.
module sem_grad import sem_pkg::*; #(
  parameter int MAX_LINE_WIDTH = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cmd_t                              cmd_i,
  input  logic [$clog2(MAX_LINE_WIDTH)-1:0] cmd_addr_i,
  input  logic [$clog2(MAX_LINE_WIDTH)-1:0] rd_addr_i,
  output logic                              push_o,
  output grad_t                             grad_o
);

  localparam int CW = $clog2(MAX_LINE_WIDTH);
  localparam int LW = 2 * PIX_W;

  logic             we;
  logic [LW-1:0]    wdata, rdata, line;
  logic             fwd_q;
  logic [LW-1:0]    fwd_data_q;
  logic [PIX_W-1:0] top, mid;
  logic [PIX_W-1:0] win_q [3][3];
  logic [PIX_W-1:0] win_d [3][3];
  logic [PIX_W+1:0] sum_r, sum_l, sum_t, sum_b;

  // Both previous rows share one RAM word: {upper, middle}
  sem_ram #(
    .Width(LW),
    .Depth(MAX_LINE_WIDTH)
  ) u_line_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(cmd_addr_i),
    .wdata_i(wdata),
    .raddr_i(rd_addr_i),
    .rdata_o(rdata)
  );

  // Same-column write and read in one cycle: forward the new word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else begin
      fwd_q <= we && (cmd_addr_i == rd_addr_i);
    end
  end

  always_ff @(posedge clk_i) begin
    fwd_data_q <= wdata;
  end

  assign line  = fwd_q ? fwd_data_q : rdata;
  assign top   = line[LW-1:PIX_W];
  assign mid   = line[PIX_W-1:0];
  assign we    = cmd_i.valid && cmd_i.pixel;
  assign wdata = {mid, cmd_i.pix};

  // Window shifts left by one column per pixel
  always_comb begin
    win_d = win_q;
    if (we) begin
      for (int r = 0; r < 3; r++) begin
        win_d[r][0] = win_q[r][1];
        win_d[r][1] = win_q[r][2];
      end
      win_d[0][2] = top;
      win_d[1][2] = mid;
      win_d[2][2] = cmd_i.pix;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else begin
      win_q <= win_d;
    end
  end

  // Sobel kernels as weighted column and row sums (1, 2, 1)
  assign sum_r = (PIX_W+2)'(win_d[0][2]) + (PIX_W+2)'({win_d[1][2], 1'b0})
               + (PIX_W+2)'(win_d[2][2]);
  assign sum_l = (PIX_W+2)'(win_d[0][0]) + (PIX_W+2)'({win_d[1][0], 1'b0})
               + (PIX_W+2)'(win_d[2][0]);
  assign sum_t = (PIX_W+2)'(win_d[0][0]) + (PIX_W+2)'({win_d[0][1], 1'b0})
               + (PIX_W+2)'(win_d[0][2]);
  assign sum_b = (PIX_W+2)'(win_d[2][0]) + (PIX_W+2)'({win_d[2][1], 1'b0})
               + (PIX_W+2)'(win_d[2][2]);

  assign grad_o.gx        = $signed({1'b0, sum_r}) - $signed({1'b0, sum_l});
  assign grad_o.gy        = $signed({1'b0, sum_t}) - $signed({1'b0, sum_b});
  assign grad_o.use_sobel = cmd_i.use_sobel;
  assign grad_o.last      = cmd_i.last;
  assign push_o           = cmd_i.valid && cmd_i.emit;

endmodule

### rtl/core/sem_queue.sv
// Short queue of gradient requests between front and back.
module sem_queue import sem_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  grad_t             data_i,
  input  logic              pop_i,
  output grad_t             data_o,
  output logic              valid_o,
  output logic [QCNT_W-1:0] count_o
);

  grad_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_q, rptr_q;
  logic [QCNT_W-1:0] count_q;

  // Pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (pop_i) begin
        rptr_q <= rptr_q + 1'b1;
      end
      count_q <= count_q + QCNT_W'(push_i) - QCNT_W'(pop_i);
    end
  end

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= data_i;
    end
  end

  assign data_o  = mem_q[rptr_q];
  assign valid_o = count_q != '0;
  assign count_o = count_q;

endmodule

### rtl/core/sem_back.sv
// Back part: L1 magnitude, saturation and the result register.
module sem_back import sem_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  grad_t            head_i,
  input  logic             head_valid_i,
  output logic             deq_o,
  input  logic             pop_i,
  output logic             out_valid_o,
  output logic [PIX_W-1:0] edge_value_o,
  output logic             frame_last_o
);

  logic                out_valid_q, out_valid_d, load;
  logic [PIX_W-1:0]    edge_q;
  logic                last_q;
  logic [GRAD_W-1:0]   abs_x, abs_y;
  logic [GRAD_W:0]     mag;
  logic [PIX_W-1:0]    sat;

  // |Gx| + |Gy|, clipped to the pixel range
  assign abs_x = head_i.gx[GRAD_W-1] ? GRAD_W'(-head_i.gx) : GRAD_W'(head_i.gx);
  assign abs_y = head_i.gy[GRAD_W-1] ? GRAD_W'(-head_i.gy) : GRAD_W'(head_i.gy);
  assign mag   = {1'b0, abs_x} + {1'b0, abs_y};
  assign sat   = (mag > (GRAD_W+1)'({PIX_W{1'b1}})) ? {PIX_W{1'b1}} : mag[PIX_W-1:0];

  // Refill the result register when it is free or being taken
  assign load        = !out_valid_q || pop_i;
  assign deq_o       = load && head_valid_i;
  assign out_valid_d = load ? head_valid_i : out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (deq_o) begin
      edge_q <= head_i.use_sobel ? sat : '0;
      last_q <= head_i.last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign edge_value_o = edge_q;
  assign frame_last_o = last_q;

endmodule

### dv/sobel_edge_checker.sv
// Checker for the Sobel edge stream unit: predicts each edge result and compares it.
`timescale 1ns / 100ps

module sobel_edge_checker import sem_pkg::*; #(
  parameter int LINE_DEPTH = 1024
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  input  logic                      cfg_ready_i,
  input  logic [CFG_INDEX_W-1:0]    cfg_index_i,
  input  logic [CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                      push_i,
  input  logic                      full_i,
  input  logic                      kind_i,
  input  logic [PIX_W-1:0]          pixel_in_i,
  input  logic                      empty_i,
  input  logic                      pop_i,
  input  logic [PIX_W-1:0]          edge_value_i,
  input  logic                      frame_last_i,
  output int                        fail_count_o,
  output int                        pending_o
);

  typedef struct {
    logic [PIX_W-1:0] edge_value;
    logic             frame_last;
  } edge_result_t;

  // Predicted block state
  logic [FRAME_WIDTH_W-1:0]  width_reg;
  logic [FRAME_HEIGHT_W-1:0] height_reg;
  logic [PIX_W-1:0]          upper_row  [LINE_DEPTH];
  logic [PIX_W-1:0]          middle_row [LINE_DEPTH];
  logic [PIX_W-1:0]          win [3][3];
  int unsigned               col_pos;
  int unsigned               row_pos;
  int unsigned               emitted_cnt;

  edge_result_t              pending_edges [$];
  int                        fails;

  // Register values as the datapath uses them
  function automatic int unsigned active_width();
    int unsigned w;
    w = 32'(width_reg);
    if (w < MIN_DIM) w = MIN_DIM;
    if (w > LINE_DEPTH) w = LINE_DEPTH;
    return w;
  endfunction

  function automatic int unsigned active_height();
    int unsigned h;
    h = 32'(height_reg);
    if (h < MIN_DIM) h = MIN_DIM;
    if (h > MAX_FRAME_HEIGHT) h = MAX_FRAME_HEIGHT;
    return h;
  endfunction

  // L1 gradient magnitude of the current window, clipped to 8 bits
  function automatic int unsigned window_magnitude();
    int gx;
    int gy;
    int mag;
    gx = int'(win[0][2]) - int'(win[0][0]) + 2 * (int'(win[1][2]) - int'(win[1][0]))
       + int'(win[2][2]) - int'(win[2][0]);
    gy = int'(win[0][0]) + 2 * int'(win[0][1]) + int'(win[0][2])
       - int'(win[2][0]) - 2 * int'(win[2][1]) - int'(win[2][2]);
    if (gx < 0) gx = -gx;
    if (gy < 0) gy = -gy;
    mag = gx + gy;
    return (mag > 255) ? 255 : mag;
  endfunction

  // Queue one expected result; the frame closes once every position is out
  task automatic queue_result(input int unsigned value);
    edge_result_t res;
    res.edge_value = value[PIX_W-1:0];
    res.frame_last = 1'b0;
    emitted_cnt++;
    if (emitted_cnt >= active_width() * active_height()) begin
      res.frame_last = 1'b1;
      emitted_cnt    = 0;
      col_pos        = 0;
      row_pos        = 0;
    end
    pending_edges.push_back(res);
  endtask

  // Advance the predicted state by one accepted request
  task automatic predict_edge(input logic item_kind, input logic [PIX_W-1:0] pix);
    int unsigned w;
    int unsigned h;
    int unsigned c;
    int unsigned r;
    int unsigned idx;
    int unsigned rr;
    int unsigned cc;
    int unsigned value;
    w = active_width();
    h = active_height();
    c = col_pos;
    r = row_pos;
    // Frame tail: every request pushes out one border zero
    if (r == 0 && c == 0 && emitted_cnt != 0) begin
      queue_result(0);
      return;
    end
    if (item_kind == KIND_FLUSH) return;

    idx = c % LINE_DEPTH;
    for (int i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2]       = upper_row[idx];
    win[1][2]       = middle_row[idx];
    win[2][2]       = pix;
    upper_row[idx]  = middle_row[idx];
    middle_row[idx] = pix;

    value = (r >= 2 && c >= 2) ? window_magnitude() : 0;

    c++;
    if (c >= w) begin
      c = 0;
      r++;
      if (r >= h) r = 0;
    end
    col_pos = c;
    row_pos = r;

    // Position of the pixel just taken; results start one row and one pixel in
    rr = (c == 0) ? r - 1 : r;
    cc = (c == 0) ? w - 1 : c - 1;
    if (c == 0 && r == 0) rr = h - 1;
    if (rr >= 2 || (rr == 1 && cc >= 1)) queue_result(value);
  endtask

  // Watch all three channels
  always @(posedge clk_i or negedge rst_ni) begin
    edge_result_t want;
    if (!rst_ni) begin
      width_reg   = FRAME_WIDTH_W'(FRAME_WIDTH_RST);
      height_reg  = FRAME_HEIGHT_W'(FRAME_HEIGHT_RST);
      col_pos     = 0;
      row_pos     = 0;
      emitted_cnt = 0;
      fails       = 0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) win[i][j] = '0;
      pending_edges.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_FRAME_WIDTH:  width_reg  = cfg_data_i[FRAME_WIDTH_W-1:0];
          REG_FRAME_HEIGHT: height_reg = cfg_data_i[FRAME_HEIGHT_W-1:0];
          default: ;
        endcase
      end

      if (push_i && !full_i) predict_edge(kind_i, pixel_in_i);

      if (pop_i && !empty_i) begin
        if (pending_edges.size() == 0) begin
          $display("%0t: unexpected result: expected none, got edge_value %0d frame_last %0d",
                   $time, edge_value_i, frame_last_i);
          fails++;
        end else begin
          want = pending_edges.pop_front();
          if (edge_value_i !== want.edge_value) begin
            $display("%0t: edge_value mismatch: expected %0d, got %0d",
                     $time, want.edge_value, edge_value_i);
            fails++;
          end
          if (frame_last_i !== want.frame_last) begin
            $display("%0t: frame_last mismatch: expected %0d, got %0d",
                     $time, want.frame_last, frame_last_i);
            fails++;
          end
        end
      end

      fail_count_o <= fails;
      pending_o    <= pending_edges.size();
    end
  end

endmodule

### dv/tb_sobel_edge_magnitude_stream_unit.sv
// Testbench top for the Sobel edge stream unit: stimulus, flow control and verdict.
`timescale 1ns / 100ps

module tb_sobel_edge_magnitude_stream_unit;
  import sem_pkg::*;

  localparam int HOLD_CYCLES    = 400;
  localparam int SETTLE_CYCLES  = 8;
  localparam int WATCHDOG_LIMIT = 5000;

  // Directed frame: strong vertical step through the only interior pixel
  localparam logic [8:0][PIX_W-1:0] STEP_FRAME = {
    8'd255, 8'd0,   8'd0,
    8'd255, 8'd128, 8'd0,
    8'd255, 8'd0,   8'd0
  };

  logic                  clk_i     = 1'b0;
  logic                  rst_ni    = 1'b0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  cfg_reg_e              cfg_index = REG_FRAME_WIDTH;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  push      = 1'b0;
  logic                  full;
  logic                  kind      = KIND_PIXEL;
  logic [PIX_W-1:0]      pixel_in  = '0;
  logic                  empty;
  logic                  pop       = 1'b0;
  logic [PIX_W-1:0]      edge_value;
  logic                  frame_last;

  int                    fail_count;
  int                    pending;
  int unsigned           tx_idle_pct = 37;
  int unsigned           rx_idle_pct = 53;
  int                    hold_requests = 0;
  int                    holds_served = 0;
  int                    hold_left = 0;
  int                    idle_cycles = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  sobel_edge_magnitude_stream_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .push         (push),
    .full         (full),
    .kind_i       (kind),
    .pixel_in_i   (pixel_in),
    .empty        (empty),
    .pop          (pop),
    .edge_value_o (edge_value),
    .frame_last_o (frame_last)
  );

  sobel_edge_checker edge_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .push_i       (push),
    .full_i       (full),
    .kind_i       (kind),
    .pixel_in_i   (pixel_in),
    .empty_i      (empty),
    .pop_i        (pop),
    .edge_value_i (edge_value),
    .frame_last_i (frame_last),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Result side: random stalls, plus a long hold-off on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (hold_left != 0) begin
      pop <= 1'b0;
      hold_left--;
    end else if (holds_served != hold_requests) begin
      holds_served = hold_requests;
      hold_left    = HOLD_CYCLES;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog: too long without any request moving on any channel
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("sobel_edge_magnitude_stream_unit verification failed");
      $finish;
    end
  end

  // Offer one request, with random gaps in front of it
  task automatic send_item(input logic item_kind, input logic [PIX_W-1:0] pix);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push     <= 1'b1;
    kind     <= item_kind;
    pixel_in <= pix;
    do @(posedge clk_i); while (full);
  endtask

  task automatic wait_for_results();
    push <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
  endtask

  // New frame size, only once the block has gone quiet
  task automatic reconfigure(input logic [CFG_DATA_W-1:0] w_data,
                             input logic [CFG_DATA_W-1:0] h_data);
    wait_for_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    write_reg(REG_FRAME_WIDTH, w_data);
    write_reg(REG_FRAME_HEIGHT, h_data);
    cfg_valid <= 1'b0;
  endtask

  // Half uniform noise, half a smooth patch around a per-frame level
  function automatic logic [PIX_W-1:0] pick_pixel(input logic [PIX_W-1:0] base);
    logic [PIX_W-1:0] p;
    if ($urandom_range(1) != 0) p = PIX_W'($urandom_range(255));
    else p = base + PIX_W'($urandom_range(7));
    return p;
  endfunction

  // One full frame with stray flushes, then the tail of width+1 requests
  task automatic run_frame(input int w, input int h, input int hold_at, input int pause_at);
    logic [PIX_W-1:0] base;
    base = PIX_W'($urandom_range(248));
    for (int n = 0; n < w * h; n++) begin
      if (n == hold_at) hold_requests <= hold_requests + 1;
      if (n == pause_at) wait_for_results();
      if ($urandom_range(9) == 0) send_item(KIND_FLUSH, PIX_W'($urandom_range(255)));
      send_item(KIND_PIXEL, pick_pixel(base));
    end
    // Tail: pixels here are dropped and act as flushes
    for (int n = 0; n <= w; n++)
      send_item(($urandom_range(1) != 0) ? KIND_FLUSH : KIND_PIXEL,
                PIX_W'($urandom_range(255)));
  endtask

  task automatic run_setting(input logic [CFG_DATA_W-1:0] w_data,
                             input logic [CFG_DATA_W-1:0] h_data,
                             input int w, input int h, input int frames,
                             input int hold_at, input int pause_at);
    reconfigure(w_data, h_data);
    repeat (frames) run_frame(w, h, hold_at, pause_at);
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: smallest frame, saturated interior, flush corner cases
    reconfigure(13'd3, 13'd3);
    send_item(KIND_FLUSH, 8'hA5);
    for (int i = 0; i < 9; i++) send_item(KIND_PIXEL, STEP_FRAME[i]);
    send_item(KIND_FLUSH, 8'h00);
    send_item(KIND_PIXEL, 8'h5A);
    send_item(KIND_FLUSH, 8'hFF);
    send_item(KIND_FLUSH, 8'h00);
    send_item(KIND_FLUSH, 8'hFF);

    // Both sides idling, receiver the slower
    run_setting(13'h1800, 13'd2, 3, 3, 6, -1, -1);
    run_setting(13'd7, 13'd5, 7, 5, 3, -1, -1);
    run_setting(13'd60, 13'd3, 60, 3, 1, 120, -1);

    // Sender the slower
    tx_idle_pct = 53;
    rx_idle_pct <= 37;
    run_setting(13'd16, 13'd9, 16, 9, 1, -1, 70);
    run_setting(13'd5, 13'd4, 5, 4, 3, -1, -1);
    run_setting(13'd1, 13'd6, 3, 6, 2, -1, -1);

    // Full rate on both sides
    tx_idle_pct = 0;
    rx_idle_pct <= 0;
    run_setting(13'd3, 13'd3, 3, 3, 6, -1, -1);
    run_setting(13'd12, 13'd6, 12, 6, 2, 40, 60);

    wait_for_results();
    repeat (2 * SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("sobel_edge_magnitude_stream_unit verification clean");
    else
      $display("sobel_edge_magnitude_stream_unit verification failed");
    $finish;
  end

endmodule
